FILE: rtl/modular_power_with_overflow_flag_core_assert.svh
// ---------------------------------------------------------------------------
// modular power core assertion macros
// concurrent checks that can be compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef MODULAR_POWER_WITH_OVERFLOW_FLAG_CORE_ASSERT_SVH
`define MODULAR_POWER_WITH_OVERFLOW_FLAG_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define MPOF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define MPOF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define MPOF_ASSERT(lbl, clk, rstn, prop, msg)
`define MPOF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: rtl/mpof_pkg.sv
// ---------------------------------------------------------------------------
// mpof_pkg
// widths, transaction types and sequencer codes of the modular power core
// ---------------------------------------------------------------------------
`default_nettype none

package mpof_pkg;

    localparam int WORD_WIDTH    = 30;
    localparam int EXP_WIDTH     = 32;
    localparam int PROD_WIDTH    = 2 * WORD_WIDTH;
    localparam int RED_CNT_WIDTH = $clog2(PROD_WIDTH);

    localparam logic [WORD_WIDTH-1:0]    MODULUS_RESET = WORD_WIDTH'(1000000007);
    localparam logic [RED_CNT_WIDTH-1:0] RED_LAST      = RED_CNT_WIDTH'(PROD_WIDTH - 1);

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [EXP_WIDTH-1:0]  t_exp;
    typedef logic [PROD_WIDTH-1:0] t_prod;

    typedef struct packed {
        t_word                       base;
        logic signed [EXP_WIDTH-1:0] exponent;
    } t_in_item;

    typedef struct packed {
        t_word power_result;
        logic  overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_ACC,
        ST_WAIT_ACC,
        ST_MUL_SQ,
        ST_WAIT_SQ,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_CHECK,
        MM_REDUCE
    } t_mm_phase;

    typedef struct packed {
        logic done;
        logic reduced;
    } t_mm_stat;

endpackage

`default_nettype wire

FILE: rtl/modular_power_with_overflow_flag_core.sv
// ---------------------------------------------------------------------------
// modular_power_with_overflow_flag_core
// base to a signed power modulo a programmable modulus, with overflow flag
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The result is
// shown on o_result for exactly one cycle with o_strobe high and must be
// captured then; there is no backpressure. A negative exponent or a zero
// modulus gives its result in the cycle after acceptance. Otherwise the core
// walks the exponent from bit 0 up to its highest set bit with right-to-left
// square and multiply. Every product, of the multiply and of the squaring,
// goes through the one shared 30x30 multiplier and its bit-serial reducer,
// which reduces a product only when it exceeds the modulus. The modulus
// register (i_cfg_we / i_cfg_wdata) may only be written while idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "modular_power_with_overflow_flag_core_assert.svh"

module modular_power_with_overflow_flag_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // modulus register write
    input  logic                i_cfg_we,
    input  mpof_pkg::t_word     i_cfg_wdata,
    // input transaction
    input  logic                start,
    output logic                busy,
    input  mpof_pkg::t_in_item  i_item,
    // result transaction
    output logic                o_strobe,
    output mpof_pkg::t_out_item o_result
);
    import mpof_pkg::*;

    // sequencer state
    t_state    r_state;
    t_state    n_state;

    // configuration
    t_word     r_modulus;

    // working registers: running result, running square, remaining exponent
    t_word     r_acc;
    t_word     r_sq;
    t_exp      r_exp;
    logic      r_flag;

    // result register
    t_out_item r_out;
    logic      r_strobe;

    // shared unit interface
    logic      mm_start;
    t_word     mm_op_a;
    t_word     mm_res;
    t_mm_stat  mm_stat;

    // control decoded from state
    logic      take_item;
    logic      take_acc;
    logic      take_sq;
    logic      finish;
    logic      exp_neg;
    logic      mod_zero;
    logic      accept;

    assign accept   = start && !busy;
    assign exp_neg  = i_item.exponent[EXP_WIDTH-1];
    assign mod_zero = (r_modulus == '0);

    mpof_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_op_a    (mm_op_a),
        .i_op_b    (r_sq),
        .i_modulus (r_modulus),
        .o_res     (mm_res),
        .o_stat    (mm_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // negative exponent and zero modulus answer at once
                if (accept && !exp_neg && !mod_zero) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_exp == '0)  n_state = ST_FINISH;
                else if (r_exp[0]) n_state = ST_MUL_ACC;
                else               n_state = ST_MUL_SQ;
            end
            ST_MUL_ACC: begin
                n_state = ST_WAIT_ACC;
            end
            ST_WAIT_ACC: begin
                if (mm_stat.done) n_state = ST_MUL_SQ;
            end
            ST_MUL_SQ: begin
                n_state = ST_WAIT_SQ;
            end
            ST_WAIT_SQ: begin
                if (mm_stat.done) n_state = ST_CHECK;
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        mm_start  = 1'b0;
        mm_op_a   = r_sq;
        take_item = 1'b0;
        take_acc  = 1'b0;
        take_sq   = 1'b0;
        finish    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                take_item = accept;
            end
            ST_MUL_ACC: begin
                // running result times running square
                mm_start = 1'b1;
                mm_op_a  = r_acc;
            end
            ST_WAIT_ACC: begin
                take_acc = mm_stat.done;
            end
            ST_MUL_SQ: begin
                // square the running square, also after the top bit
                mm_start = 1'b1;
            end
            ST_WAIT_SQ: begin
                take_sq = mm_stat.done;
            end
            ST_FINISH: begin
                finish = 1'b1;
            end
            default: begin
                mm_start = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_modulus <= MODULUS_RESET;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) r_modulus <= i_cfg_wdata;
            // fast answers strobe right after acceptance, others after finish
            r_strobe <= (take_item && (exp_neg || mod_zero)) || finish;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (take_item) begin
            r_acc  <= WORD_WIDTH'(1);
            r_sq   <= i_item.base;
            r_exp  <= i_item.exponent;
            r_flag <= 1'b0;
            if (exp_neg) begin
                r_out.power_result <= WORD_WIDTH'(1);
                r_out.overflow     <= 1'b0;
            end else if (mod_zero) begin
                r_out.power_result <= '0;
                r_out.overflow     <= 1'b0;
            end
        end
        if (take_acc) begin
            r_acc  <= mm_res;
            r_flag <= r_flag | mm_stat.reduced;
        end
        if (take_sq) begin
            r_sq   <= mm_res;
            r_flag <= r_flag | mm_stat.reduced;
            r_exp  <= r_exp >> 1;
        end
        if (finish) begin
            // running result never exceeds the modulus, so the last
            // reduction is a compare against it
            r_out.power_result <= (r_acc == r_modulus) ? '0 : r_acc;
            r_out.overflow     <= r_flag;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // result strobe only ever appears with the sequencer back at rest
    `MPOF_ASSERT(a_strobe_idle, i_clk, i_rst_n, !o_strobe || (r_state == ST_IDLE), "strobe while working")
    // shared unit reports completion only while the sequencer waits for it
    `MPOF_ASSERT(a_done_waiting, i_clk, i_rst_n, !mm_stat.done || (r_state == ST_WAIT_ACC) || (r_state == ST_WAIT_SQ), "unexpected unit done")
    // a transaction that needs iteration makes the block busy next cycle
    `MPOF_ASSERT(a_accept_busy, i_clk, i_rst_n, (accept && !exp_neg && !mod_zero) |=> busy, "accepted transaction not started")
    // no unit start is issued while the unit is still reporting
    `MPOF_ASSERT_NEVER(a_start_overlap, i_clk, i_rst_n, mm_start && mm_stat.done, "unit start overlaps done")

endmodule

`default_nettype wire

FILE: rtl/mpof_mulmod.sv
// ---------------------------------------------------------------------------
// mpof_mulmod
// shared multiply unit with conditional bit-serial reduction by the modulus
// ---------------------------------------------------------------------------
`default_nettype none

module mpof_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mpof_pkg::t_word   i_op_a,
    input  mpof_pkg::t_word   i_op_b,
    input  mpof_pkg::t_word   i_modulus,
    output mpof_pkg::t_word   o_res,
    output mpof_pkg::t_mm_stat o_stat
);
    import mpof_pkg::*;

    t_mm_phase                r_phase;
    t_mm_phase                n_phase;
    t_prod                    r_prod;
    t_word                    r_rem;
    t_word                    r_res;
    logic [RED_CNT_WIDTH-1:0] r_cnt;
    logic                     r_done;
    logic                     n_done;
    logic                     r_reduced;

    t_prod                    prod_full;
    logic                     over;
    logic [WORD_WIDTH:0]      shifted;
    logic [WORD_WIDTH:0]      trial;
    t_word                    rem_step;

    assign prod_full = PROD_WIDTH'(i_op_a) * PROD_WIDTH'(i_op_b);
    // only a product strictly above the modulus is reduced
    assign over      = r_prod > PROD_WIDTH'(i_modulus);

    // restoring remainder, one product bit per cycle, msb first
    assign shifted  = {r_rem, r_prod[PROD_WIDTH-1]};
    assign trial    = shifted - {1'b0, i_modulus};
    assign rem_step = (shifted >= {1'b0, i_modulus}) ? trial[WORD_WIDTH-1:0]
                                                      : shifted[WORD_WIDTH-1:0];

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        case (r_phase)
            MM_IDLE: begin
                if (i_start) n_phase = MM_CHECK;
            end
            MM_CHECK: begin
                n_phase = over ? MM_REDUCE : MM_IDLE;
                n_done  = !over;
            end
            MM_REDUCE: begin
                if (r_cnt == RED_LAST) begin
                    n_phase = MM_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MM_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
            case (r_phase)
                MM_IDLE: begin
                    if (i_start) r_prod <= prod_full;
                end
                MM_CHECK: begin
                    if (over) begin
                        r_rem <= '0;
                        r_cnt <= '0;
                    end else begin
                        r_res     <= r_prod[WORD_WIDTH-1:0];
                        r_reduced <= 1'b0;
                    end
                end
                MM_REDUCE: begin
                    r_rem  <= rem_step;
                    r_prod <= r_prod << 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == RED_LAST) begin
                        r_res     <= rem_step;
                        r_reduced <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res          = r_res;
    assign o_stat.done    = r_done;
    assign o_stat.reduced = r_reduced;

endmodule

`default_nettype wire
